### src/tx_ring_packetizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the transmit ring packetiser
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef TX_RING_PACKETIZER_UNIT_MACROS_SVH
`define TX_RING_PACKETIZER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TXRP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TXRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/txrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txrp_pkg
// Shared constants, beat types and control types of the transmit ring
// packetiser.
// ----------------------------------------------------------------------------
package txrp_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int PACKET_MAX = 20;

  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int LEN_W     = $clog2(PACKET_MAX + 1);
  localparam int PKT_LEN_W = 5;
  localparam int TIMEOUT_W = 16;
  localparam int LINK_W    = 3;
  localparam int COUNT_W   = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [LINK_W-1:0]    LINK_RESET    = 3'd1;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_WRITE      = 2'd0;
  localparam logic [1:0] OP_TICK       = 2'd1;
  localparam logic [1:0] OP_TX_DONE    = 2'd2;
  localparam logic [1:0] OP_DISCONNECT = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       end_of_chunk;
  } txrp_item_t;

  typedef struct packed {
    logic [7:0]           packet_byte;
    logic                 last_in_packet;
    logic [PKT_LEN_W-1:0] packet_length;
    logic [COUNT_W-1:0]   accepted_total;
  } txrp_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_EMIT
  } txrp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // apply the accepted beat to the ring state
    logic load;   // start a packet: latch its length, take a slot
    logic fetch;  // read the ring entry at the read pointer
    logic emit;   // present the fetched byte, advance the read pointer
  } txrp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic send_ok;
    logic last;
  } txrp_status_t;

endpackage

### src/txrp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txrp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module txrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/txrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txrp_ctrl
// Sequencer: takes a beat, decides on a send and walks the packet bytes.
// ----------------------------------------------------------------------------
module txrp_ctrl
  import txrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  txrp_item_t   item,
  input  txrp_status_t status,
  output txrp_cmd_t    cmd,
  output logic         busy,
  output logic         result_strobe
);

  txrp_state_t state;
  txrp_state_t state_next;
  logic        accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.opcode)
            OP_WRITE:      state_next = item.end_of_chunk ? ST_CHECK : ST_IDLE;
            OP_DISCONNECT: state_next = ST_IDLE;
            default:       state_next = ST_CHECK;
          endcase
        end
      end
      ST_CHECK: state_next = status.send_ok ? ST_FETCH : ST_IDLE;
      ST_FETCH: state_next = ST_EMIT;
      ST_EMIT:  state_next = status.last ? ST_IDLE : ST_FETCH;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.exec      = accept;
    cmd.load      = (state == ST_CHECK) && status.send_ok;
    cmd.fetch     = (state == ST_FETCH);
    cmd.emit      = (state == ST_EMIT);
    busy          = (state != ST_IDLE);
    result_strobe = (state == ST_EMIT);
  end

endmodule

### src/txrp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txrp_datapath
// Ring pointers, slot and idle bookkeeping, configuration and ring storage.
// ----------------------------------------------------------------------------
module txrp_datapath
  import txrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  txrp_item_t           item,
  input  txrp_cmd_t            cmd,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output txrp_status_t         status,
  output txrp_result_t         result
);

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [LINK_W-1:0]    link_slots;
  logic [PTR_W-1:0]     read_pointer;
  logic [PTR_W-1:0]     write_pointer;
  logic [LINK_W-1:0]    slots_in_use;
  logic [TIMEOUT_W-1:0] idle_count;
  logic                 timer_armed;
  logic [COUNT_W-1:0]   accepted_count;
  logic [LEN_W-1:0]     packet_len;
  logic [LEN_W-1:0]     remain;

  logic [PTR_W-1:0]     pending;
  logic                 ring_full;
  logic                 full_packet;
  logic [LEN_W-1:0]     send_len;
  logic                 write_ok;
  logic [7:0]           ring_rd_data;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pending bytes between the pointers, taking the wrap into account.
  always_comb begin
    if (write_pointer >= read_pointer) begin
      pending = write_pointer - read_pointer;
    end else begin
      pending = PTR_W'(RING_DEPTH) - read_pointer + write_pointer;
    end
  end

  assign ring_full   = 32'(pending) >= 32'(RING_DEPTH - 1);
  assign full_packet = 32'(pending) >= 32'(PACKET_MAX);
  assign send_len    = full_packet ? LEN_W'(PACKET_MAX) : LEN_W'(pending);
  assign write_ok    = cmd.exec && (item.opcode == OP_WRITE) && !ring_full;

  assign status.send_ok = (pending != '0) && (slots_in_use < link_slots) &&
                          (full_packet || (timer_armed && (idle_count >= timeout_ticks)));
  assign status.last    = (remain == LEN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      link_slots    <= LINK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        CFG_SLOTS:   link_slots    <= cfg_data[LINK_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer   <= '0;
      write_pointer  <= '0;
      slots_in_use   <= '0;
      idle_count     <= '0;
      timer_armed    <= 1'b0;
      accepted_count <= '0;
      remain         <= '0;
    end else begin
      if (cmd.exec) begin
        unique case (item.opcode)
          OP_WRITE: begin
            if (!ring_full) begin
              write_pointer  <= next_pos(write_pointer);
              accepted_count <= accepted_count + 1'b1;
              timer_armed    <= 1'b1;
              idle_count     <= '0;
            end
          end
          OP_TICK: begin
            if (timer_armed && (idle_count != '1)) begin
              idle_count <= idle_count + 1'b1;
            end
          end
          OP_TX_DONE: begin
            if (slots_in_use != '0) begin
              slots_in_use <= slots_in_use - 1'b1;
            end
          end
          OP_DISCONNECT: begin
            read_pointer  <= '0;
            write_pointer <= '0;
            slots_in_use  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.load) begin
        remain       <= send_len;
        slots_in_use <= slots_in_use + 1'b1;
        if (!full_packet) begin
          idle_count <= '0;
        end
      end
      if (cmd.emit) begin
        read_pointer <= next_pos(read_pointer);
        remain       <= remain - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      packet_len <= send_len;
    end
  end

  txrp_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (write_ok),
    .wr_addr (write_pointer),
    .wr_data (item.data_byte),
    .rd_en   (cmd.fetch),
    .rd_addr (read_pointer),
    .rd_data (ring_rd_data)
  );

  always_comb begin
    result.packet_byte    = ring_rd_data;
    result.last_in_packet = status.last;
    result.packet_length  = PKT_LEN_W'(packet_len);
    result.accepted_total = accepted_count;
  end

endmodule

### src/tx_ring_packetizer_unit.sv
`timescale 1ns / 1ps
`include "tx_ring_packetizer_unit_macros.svh"
// ----------------------------------------------------------------------------
// tx_ring_packetizer_unit
// Byte ring that gathers written bytes into link packets, flushing short
// packets after an idle timeout.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Packet bytes leave on
// result, one per result_strobe pulse, and the receiver has no way to stall
// them: it must take each byte in the cycle in which it is shown. A write
// without end_of_chunk and a disconnect end in the cycle in which they are
// taken. Every other beat then passes through a state that decides whether a
// packet goes out, and each byte of a packet is first read from the ring
// memory through its registered read port and then presented. busy is low in
// the cycle in which a beat is taken and high for the rest of that beat. The
// ring keeps one entry free, so a write that finds RING_DEPTH-1 bytes
// pending is dropped. A packet holds the oldest
// min(pending, PACKET_MAX) bytes and goes out when a full packet is pending,
// or when the idle timer is armed and has reached timeout_ticks, and only
// while fewer than link_slots transmit slots are in use. The ring memory is
// not cleared after reset; nothing is ever read from it that was not written.
// Configuration may be written only while busy is low.
// ----------------------------------------------------------------------------
module tx_ring_packetizer_unit
  import txrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  txrp_item_t           item,
  output logic                 result_strobe,
  output txrp_result_t         result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Command and status buses between the sequencer and the datapath.
  txrp_cmd_t    cmd;
  txrp_status_t status;

  // The sequencer owns the handshake and the packet walk.
  txrp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy),
    .result_strobe (result_strobe)
  );

  // The datapath holds the ring, its pointers, the timer and the slot count.
  txrp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result)
  );

  // A packet byte is only ever shown while a beat is in progress.
  `TXRP_ASSERT_SAME(a_strobe_busy, result_strobe, busy, "result strobe while idle")
  // Each byte needs a fresh ring read, so strobes never come back to back.
  `TXRP_ASSERT_NEXT(a_strobe_gap, result_strobe, !result_strobe, "back to back strobes")
  // The cycle after a beat is taken is spent on the send decision, or in idle.
  `TXRP_ASSERT_NEXT(a_accept_gap, start && !busy, !result_strobe, "strobe right after accept")
  // The final byte of a packet ends the beat.
  `TXRP_ASSERT_NEXT(a_last_done, result_strobe && result.last_in_packet, !busy,
                    "still busy after last byte")

endmodule
